FILE: src/gbd_pkg.sv
// Package: shared constants, codes, controller states and command/status bundles.
package gbd_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 8192;

  localparam int OP_W     = 2;
  localparam int NB_W     = 10;
  localparam int STATUS_W = 2;
  localparam int CID_W    = 10;
  localparam int CNT_W    = 11;
  localparam int BETA_W   = 16;

  localparam logic [BETA_W-1:0] BETA_RST = 16'd256;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NORUN = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_QRY, S_CLR, S_SEED_RD, S_SEED_CHK, S_CUR_RD, S_CUR_WT, S_LO,
    S_LO_WT, S_HI_WT, S_EDGE, S_NB_WT, S_VX_EVAL, S_LYR_END, S_MUL, S_CMP,
    S_FIX_RD, S_FIX_WT, S_DONE
  } st_t;

  typedef struct packed {
    logic load;
    logic qry;
    logic qry_out;
    logic run_start;
    logic clr_step;
    logic seed_rd;
    logic seed;
    logic s_inc;
    logic cur_wt;
    logic e_zero;
    logic ls_prev;
    logic lo_wt;
    logic hi_wt;
    logic nb_wt;
    logic vx_eval;
    logic k_inc;
    logic lyr_end;
    logic mul;
    logic cmp;
    logic fix_wt;
    logic next_layer;
    logic clus_end;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clr_end;
    logic s_end;
    logic seed_taken;
    logic k_cur_end;
    logic u_zero;
    logic e_end;
    logic x_oob;
    logic k_nxt_end;
    logic rej;
    logic nlen_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: src/graph_ball_growing_decomposition.sv
// Top level: ball-growing graph decomposition, controller plus datapath.
//
//  channel | ports                                         | direction
//  in      | in_valid/in_ready, in_op, in_neighbour_index,  | request in
//          | in_query_vertex                               |
//  out     | out_valid/out_ready, out_status,              | result out
//          | out_cluster_id, out_cluster_count             |
//  cfg     | cfg_we, cfg_wdata (beta, Q8.8)                | write only
//
// Loads write their result register on acceptance; a query passes through S_QRY
// first. A new request is taken while the last result waits in the output
// register if out_ready is high. A run clears the cluster and layer tables, then
// checks seeds, walks each frontier vertex and its edges, closes each layer and
// fixes the vertices claimed for the next layer, paced by the single read port of
// each table. Reset is synchronous; stalls on out hold in_ready low.
module graph_ball_growing_decomposition #(
  parameter int MAX_VERTICES = gbd_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gbd_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gbd_pkg::OP_W-1:0]      in_op,
  input  logic [gbd_pkg::NB_W-1:0]      in_neighbour_index,
  input  logic [gbd_pkg::NB_W-1:0]      in_query_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gbd_pkg::STATUS_W-1:0]  out_status,
  output logic [gbd_pkg::CID_W-1:0]     out_cluster_id,
  output logic [gbd_pkg::CNT_W-1:0]     out_cluster_count,
  input  logic                          cfg_we,
  input  logic [gbd_pkg::BETA_W-1:0]    cfg_wdata
);

  gbd_pkg::cmd_t cmd;
  gbd_pkg::sts_t sts;

  gbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbd_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_op              (in_op),
    .in_neighbour_index (in_neighbour_index),
    .in_query_vertex    (in_query_vertex),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_cluster_id     (out_cluster_id),
    .out_cluster_count  (out_cluster_count),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

FILE: src/gbd_ctrl.sv
// Controller: sequences load, query and the ball-growing run.
module gbd_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [gbd_pkg::OP_W-1:0]  in_op,
  output logic                      in_ready,
  input  gbd_pkg::sts_t             sts,
  output gbd_pkg::cmd_t             cmd
);

  gbd_pkg::st_t st_r, st_nxt;
  logic acc;

  assign in_ready = (st_r == gbd_pkg::S_IDLE) && sts.out_free;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= gbd_pkg::S_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      gbd_pkg::S_IDLE: begin
        if (acc) begin
          if (in_op == gbd_pkg::OP_QUERY)    st_nxt = gbd_pkg::S_QRY;
          else if (in_op == gbd_pkg::OP_RUN) st_nxt = gbd_pkg::S_CLR;
        end
      end
      gbd_pkg::S_QRY:      st_nxt = gbd_pkg::S_IDLE;
      gbd_pkg::S_CLR:      if (sts.clr_end) st_nxt = gbd_pkg::S_SEED_RD;
      gbd_pkg::S_SEED_RD:  st_nxt = sts.s_end ? gbd_pkg::S_DONE : gbd_pkg::S_SEED_CHK;
      gbd_pkg::S_SEED_CHK: st_nxt = sts.seed_taken ? gbd_pkg::S_SEED_RD : gbd_pkg::S_CUR_RD;
      gbd_pkg::S_CUR_RD:   st_nxt = sts.k_cur_end ? gbd_pkg::S_LYR_END : gbd_pkg::S_CUR_WT;
      gbd_pkg::S_CUR_WT:   st_nxt = gbd_pkg::S_LO;
      gbd_pkg::S_LO:       st_nxt = sts.u_zero ? gbd_pkg::S_HI_WT : gbd_pkg::S_LO_WT;
      gbd_pkg::S_LO_WT:    st_nxt = gbd_pkg::S_HI_WT;
      gbd_pkg::S_HI_WT:    st_nxt = gbd_pkg::S_EDGE;
      gbd_pkg::S_EDGE:     st_nxt = sts.e_end ? gbd_pkg::S_CUR_RD : gbd_pkg::S_NB_WT;
      gbd_pkg::S_NB_WT:    st_nxt = sts.x_oob ? gbd_pkg::S_EDGE : gbd_pkg::S_VX_EVAL;
      gbd_pkg::S_VX_EVAL:  st_nxt = gbd_pkg::S_EDGE;
      gbd_pkg::S_LYR_END:  st_nxt = gbd_pkg::S_MUL;
      gbd_pkg::S_MUL:      st_nxt = gbd_pkg::S_CMP;
      gbd_pkg::S_CMP:      st_nxt = gbd_pkg::S_FIX_RD;
      gbd_pkg::S_FIX_RD: begin
        if (!sts.k_nxt_end)                 st_nxt = gbd_pkg::S_FIX_WT;
        else if (sts.rej || sts.nlen_zero)  st_nxt = gbd_pkg::S_SEED_RD;
        else                                st_nxt = gbd_pkg::S_CUR_RD;
      end
      gbd_pkg::S_FIX_WT:   st_nxt = gbd_pkg::S_FIX_RD;
      gbd_pkg::S_DONE:     st_nxt = gbd_pkg::S_IDLE;
      default:             st_nxt = gbd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (st_r)
      gbd_pkg::S_IDLE: begin
        if (acc) begin
          if (in_op == gbd_pkg::OP_QUERY)    cmd.qry = 1'b1;
          else if (in_op == gbd_pkg::OP_RUN) cmd.run_start = 1'b1;
          else                               cmd.load = 1'b1;
        end
      end
      gbd_pkg::S_QRY:      cmd.qry_out = 1'b1;
      gbd_pkg::S_CLR:      cmd.clr_step = !sts.clr_end;
      gbd_pkg::S_SEED_RD:  cmd.seed_rd = 1'b1;
      gbd_pkg::S_SEED_CHK: begin
        cmd.s_inc = sts.seed_taken;
        cmd.seed  = !sts.seed_taken;
      end
      gbd_pkg::S_CUR_RD:   ;
      gbd_pkg::S_CUR_WT:   cmd.cur_wt = 1'b1;
      gbd_pkg::S_LO: begin
        cmd.e_zero  = sts.u_zero;
        cmd.ls_prev = !sts.u_zero;
      end
      gbd_pkg::S_LO_WT:    cmd.lo_wt = 1'b1;
      gbd_pkg::S_HI_WT:    cmd.hi_wt = 1'b1;
      gbd_pkg::S_EDGE:     cmd.k_inc = sts.e_end;
      gbd_pkg::S_NB_WT:    cmd.nb_wt = 1'b1;
      gbd_pkg::S_VX_EVAL:  cmd.vx_eval = 1'b1;
      gbd_pkg::S_LYR_END:  cmd.lyr_end = 1'b1;
      gbd_pkg::S_MUL:      cmd.mul = 1'b1;
      gbd_pkg::S_CMP:      cmd.cmp = 1'b1;
      gbd_pkg::S_FIX_RD: begin
        if (sts.k_nxt_end) begin
          if (sts.rej || sts.nlen_zero) cmd.clus_end = 1'b1;
          else                          cmd.next_layer = 1'b1;
        end
      end
      gbd_pkg::S_FIX_WT:   cmd.fix_wt = 1'b1;
      gbd_pkg::S_DONE:     cmd.done = 1'b1;
      default:             ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != gbd_pkg::S_IDLE) |-> !in_ready)
    else $error("request taken while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == gbd_pkg::S_SEED_RD && sts.s_end) |=> (st_r == gbd_pkg::S_DONE))
    else $error("run did not finish after last seed");

  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.qry, cmd.run_start}))
    else $error("more than one request kind started");

endmodule

FILE: src/gbd_dp.sv
// Datapath: graph stores, cluster/layer tables, frontiers, counters and result register.
module gbd_dp #(
  parameter int MAX_VERTICES = gbd_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gbd_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gbd_pkg::OP_W-1:0]      in_op,
  input  logic [gbd_pkg::NB_W-1:0]      in_neighbour_index,
  input  logic [gbd_pkg::NB_W-1:0]      in_query_vertex,
  input  logic                          cfg_we,
  input  logic [gbd_pkg::BETA_W-1:0]    cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [gbd_pkg::STATUS_W-1:0]  out_status,
  output logic [gbd_pkg::CID_W-1:0]     out_cluster_id,
  output logic [gbd_pkg::CNT_W-1:0]     out_cluster_count,
  input  gbd_pkg::cmd_t                 cmd,
  output gbd_pkg::sts_t                 sts
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int VC = $clog2(MAX_VERTICES + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int EC = $clog2(MAX_EDGES + 1);
  localparam int IW = EC + 1;
  localparam int PW = gbd_pkg::BETA_W + IW;

  // memories
  logic [EC-1:0]              ls_mem [MAX_VERTICES];
  logic [gbd_pkg::NB_W-1:0]   ns_mem [MAX_EDGES];
  logic [VW:0]                cl_mem [MAX_VERTICES];
  logic [VW:0]                ly_mem [MAX_VERTICES];
  logic [VW-1:0]              fa_mem [MAX_VERTICES];
  logic [VW-1:0]              fb_mem [MAX_VERTICES];

  logic [EC-1:0]              ls_rd_r;
  logic [gbd_pkg::NB_W-1:0]   ns_rd_r;
  logic [VW:0]                cl_rd_r, ly_rd_r;
  logic [VW-1:0]              fa_rd_r, fb_rd_r;

  // control and counters
  logic [VC-1:0] vtot_r, s_r, k_r, cur_len_r, nlen_r, cid_r, depth_r, clusters_r;
  logic [EC-1:0] etot_r, e_r, hi_r, outs_r, same_r;
  logic [IW-1:0] internal_r;
  logic [PW-1:0] prod_r;
  logic [VW-1:0] u_r, x_r;
  logic          sel_r, rej_r, run_done_r, q_fail_r;
  logic [gbd_pkg::BETA_W-1:0] beta_r;

  logic                          out_valid_r;
  logic [gbd_pkg::STATUS_W-1:0]  out_status_r;
  logic [gbd_pkg::CID_W-1:0]     out_cid_r;
  logic [gbd_pkg::CNT_W-1:0]     out_cnt_r;

  logic          v_full, e_full, ld_full, is_add, claim;
  logic [VW-1:0] cur_x, nxt_x, cl_raddr, ls_raddr, nb_x;
  logic          cl_we, ly_we;
  logic [VW-1:0] cl_waddr, ly_waddr;
  logic [VW:0]   cl_wdata, ly_wdata;

  assign v_full = (vtot_r >= VC'(MAX_VERTICES));
  assign e_full = (etot_r >= EC'(MAX_EDGES));
  assign is_add = (in_op == gbd_pkg::OP_ADD);
  assign ld_full = is_add ? (e_full || v_full) : v_full;

  assign cur_x = sel_r ? fb_rd_r : fa_rd_r;
  assign nxt_x = sel_r ? fa_rd_r : fb_rd_r;
  assign nb_x  = VW'(ns_rd_r);
  assign claim = cmd.vx_eval && !cl_rd_r[VW];

  assign cl_raddr = cmd.qry ? VW'(in_query_vertex) : (cmd.seed_rd ? s_r[VW-1:0] : nb_x);
  assign ls_raddr = cmd.ls_prev ? (u_r - VW'(1)) : u_r;

  always_comb begin
    cl_we = 1'b1;
    cl_waddr = k_r[VW-1:0];
    cl_wdata = '0;
    priority if (cmd.clr_step) begin
      cl_waddr = k_r[VW-1:0];
    end else if (cmd.seed) begin
      cl_waddr = s_r[VW-1:0];
      cl_wdata = {1'b1, cid_r[VW-1:0]};
    end else if (claim) begin
      cl_waddr = x_r;
      cl_wdata = {1'b1, cid_r[VW-1:0]};
    end else if (cmd.fix_wt && rej_r) begin
      cl_waddr = nxt_x;
    end else begin
      cl_we = 1'b0;
    end
  end

  always_comb begin
    ly_we = 1'b1;
    ly_waddr = k_r[VW-1:0];
    ly_wdata = '0;
    priority if (cmd.clr_step) begin
      ly_waddr = k_r[VW-1:0];
    end else if (cmd.seed) begin
      ly_waddr = s_r[VW-1:0];
      ly_wdata = {1'b1, {VW{1'b0}}};
    end else if (cmd.fix_wt && !rej_r) begin
      ly_waddr = nxt_x;
      ly_wdata = {1'b1, depth_r[VW-1:0]};
    end else begin
      ly_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !is_add && !ld_full) ls_mem[vtot_r[VW-1:0]] <= etot_r;
    ls_rd_r <= ls_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && is_add && !ld_full) ns_mem[etot_r[EW-1:0]] <= in_neighbour_index;
    ns_rd_r <= ns_mem[e_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cl_we) cl_mem[cl_waddr] <= cl_wdata;
    cl_rd_r <= cl_mem[cl_raddr];
  end

  always_ff @(posedge clk) begin
    if (ly_we) ly_mem[ly_waddr] <= ly_wdata;
    ly_rd_r <= ly_mem[nb_x];
  end

  // seed always lands in bank a; claims go to the next-layer bank
  always_ff @(posedge clk) begin
    if (cmd.seed) fa_mem[0] <= s_r[VW-1:0];
    else if (claim && sel_r) fa_mem[nlen_r[VW-1:0]] <= x_r;
    fa_rd_r <= fa_mem[k_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (claim && !sel_r) fb_mem[nlen_r[VW-1:0]] <= x_r;
    fb_rd_r <= fb_mem[k_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtot_r <= '0; etot_r <= '0; clusters_r <= '0; run_done_r <= 1'b0;
      beta_r <= gbd_pkg::BETA_RST; out_valid_r <= 1'b0;
      s_r <= '0; k_r <= '0; cur_len_r <= '0; nlen_r <= '0; cid_r <= '0;
      depth_r <= '0; e_r <= '0; hi_r <= '0; outs_r <= '0; same_r <= '0;
      internal_r <= '0; sel_r <= 1'b0; rej_r <= 1'b0; q_fail_r <= 1'b0;
    end else begin
      if (cfg_we) beta_r <= cfg_wdata;
      // a new result takes the register in the cycle the old one leaves
      if (cmd.load || cmd.qry_out || cmd.done) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready)       out_valid_r <= 1'b0;

      if (cmd.load) begin
        if (!ld_full) begin
          run_done_r <= 1'b0;
          if (is_add) etot_r <= etot_r + EC'(1);
          else        vtot_r <= vtot_r + VC'(1);
        end
        out_status_r <= ld_full ? gbd_pkg::ST_FULL : gbd_pkg::ST_OK;
        out_cid_r    <= '0;
        out_cnt_r    <= gbd_pkg::CNT_W'(clusters_r);
      end
      if (cmd.qry) q_fail_r <= !run_done_r || (32'(in_query_vertex) >= 32'(vtot_r));
      if (cmd.qry_out) begin
        out_status_r <= q_fail_r ? gbd_pkg::ST_NORUN : gbd_pkg::ST_OK;
        out_cid_r    <= (q_fail_r || !cl_rd_r[VW]) ? '0
                        : gbd_pkg::CID_W'(cl_rd_r[VW-1:0]);
        out_cnt_r    <= gbd_pkg::CNT_W'(clusters_r);
      end
      if (cmd.run_start) begin
        k_r <= '0; s_r <= '0; cid_r <= '0;
      end
      if (cmd.clr_step) k_r <= k_r + VC'(1);
      if (cmd.s_inc) s_r <= s_r + VC'(1);
      if (cmd.seed) begin
        sel_r <= 1'b0; cur_len_r <= VC'(1); depth_r <= '0; internal_r <= '0;
        k_r <= '0; outs_r <= '0; same_r <= '0; nlen_r <= '0;
      end
      if (cmd.cur_wt) u_r <= cur_x;
      if (cmd.e_zero) e_r <= '0;
      if (cmd.lo_wt)  e_r <= ls_rd_r;
      if (cmd.hi_wt)  hi_r <= ls_rd_r;
      if (cmd.k_inc)  k_r <= k_r + VC'(1);
      if (cmd.nb_wt) begin
        x_r <= nb_x;
        e_r <= e_r + EC'(1);
      end
      if (cmd.vx_eval) begin
        if (!ly_rd_r[VW]) outs_r <= outs_r + EC'(1);
        if (!cl_rd_r[VW]) nlen_r <= nlen_r + VC'(1);
        else if (cl_rd_r[VW-1:0] == cid_r[VW-1:0] && ly_rd_r[VW] &&
                 ly_rd_r[VW-1:0] == depth_r[VW-1:0])
          same_r <= same_r + EC'(1);
      end
      if (cmd.lyr_end) internal_r <= internal_r + IW'(same_r >> 1);
      if (cmd.mul) prod_r <= PW'(beta_r) * PW'(internal_r);
      if (cmd.cmp) begin
        k_r <= '0;
        if (PW'({outs_r, 8'h00}) < prod_r) begin
          rej_r <= 1'b1;
        end else begin
          rej_r <= 1'b0;
          internal_r <= internal_r + IW'(outs_r);
          depth_r <= depth_r + VC'(1);
        end
      end
      if (cmd.fix_wt) k_r <= k_r + VC'(1);
      if (cmd.next_layer) begin
        sel_r <= ~sel_r; cur_len_r <= nlen_r; nlen_r <= '0; k_r <= '0;
        outs_r <= '0; same_r <= '0;
      end
      if (cmd.clus_end) begin
        cid_r <= cid_r + VC'(1);
        s_r <= s_r + VC'(1);
      end
      if (cmd.done) begin
        clusters_r   <= cid_r;
        run_done_r   <= 1'b1;
        out_status_r <= gbd_pkg::ST_OK;
        out_cid_r    <= '0;
        out_cnt_r    <= gbd_pkg::CNT_W'(cid_r);
      end
    end
  end

  assign sts.clr_end    = (k_r == vtot_r);
  assign sts.s_end      = (s_r == vtot_r);
  assign sts.seed_taken = cl_rd_r[VW];
  assign sts.k_cur_end  = (k_r == cur_len_r);
  assign sts.u_zero     = (u_r == '0);
  assign sts.e_end      = (e_r >= hi_r);
  assign sts.x_oob      = (32'(ns_rd_r) >= 32'(vtot_r));
  assign sts.k_nxt_end  = (k_r == nlen_r);
  assign sts.rej        = rej_r;
  assign sts.nlen_zero  = (nlen_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_cluster_id    = out_cid_r;
  assign out_cluster_count = out_cnt_r;

  assert property (@(posedge clk) disable iff (!rst_n) nlen_r <= vtot_r)
    else $error("next layer longer than vertex count");

  assert property (@(posedge clk) disable iff (!rst_n) etot_r <= EC'(MAX_EDGES))
    else $error("edge count past store size");

  assert property (@(posedge clk) disable iff (!rst_n) cmd.done |=> out_valid_r)
    else $error("run result not presented");

endmodule
